@@ hw/rtl/sopkm_pkg.sv @@
// Shared types, constants, the fault helper and the cell marking function of the K-map marker.
package sopkm_pkg;

	localparam int MAX_VARS = 6;
	localparam int CNT_W    = 3;
	localparam int CHAR_W   = 8;
	localparam int COL_W    = 5;
	localparam int CELL_W   = 6;
	localparam int MAP_W    = 64;
	localparam int FLT_W    = 3;

	localparam logic [CHAR_W-1:0] SUM_RESET = 8'd43;
	localparam logic [CHAR_W-1:0] NEG_RESET = 8'd39;

	localparam logic REG_SUM = 1'b0;
	localparam logic REG_NEG = 1'b1;

	localparam logic [FLT_W-1:0] FLT_NONE     = 3'd0;
	localparam logic [FLT_W-1:0] FLT_UNKNOWN  = 3'd1;
	localparam logic [FLT_W-1:0] FLT_TOO_MANY = 3'd2;
	localparam logic [FLT_W-1:0] FLT_REPEAT   = 3'd3;
	localparam logic [FLT_W-1:0] FLT_NEGATION = 3'd4;

	typedef struct packed {
		logic             row;
		logic [COL_W-1:0] col;
		logic [MAP_W-1:0] map;
	} mark_t;

	typedef struct packed {
		logic             cell_row;
		logic [COL_W-1:0] cell_column;
		logic [MAP_W-1:0] map_cells;
		logic [CNT_W-1:0] var_total;
		logic [FLT_W-1:0] term_status;
		logic             expression_end;
	} result_t;

	typedef struct packed {
		logic [1:0] count;
		result_t    first;
		result_t    second;
	} push_t;

	// Only the first fault of a term is kept.
	function automatic logic [FLT_W-1:0] set_fault(logic [FLT_W-1:0] cur,
			logic [FLT_W-1:0] code);
		return (cur == FLT_NONE) ? code : cur;
	endfunction

	// Row is variable 0; column is the Gray decode of variables 1 and up,
	// variable 1 as the MSB.
	function automatic mark_t mark_cell(logic [MAX_VARS-1:0] bits,
			logic [CNT_W-1:0] cnt, logic [MAP_W-1:0] map);
		mark_t           m;
		logic [COL_W-1:0] gray;
		logic [CNT_W-1:0] k;
		logic [CELL_W:0]  ncols;
		logic [CELL_W:0]  pos;
		gray = '0;
		k    = '0;
		for (int j = 0; j < COL_W; j++) begin
			if (cnt >= CNT_W'(2) && CNT_W'(j) <= cnt - CNT_W'(2)) begin
				k = cnt - CNT_W'(1) - CNT_W'(j);
				gray[j] = bits[k];
			end
		end
		for (int j = 0; j < COL_W; j++) begin
			m.col[j] = ^(gray >> j);
		end
		m.row = bits[0];
		if (cnt >= CNT_W'(2))
			ncols = (CELL_W+1)'(1) << (cnt - CNT_W'(1));
		else
			ncols = (CELL_W+1)'(1);
		pos = (m.row ? ncols : '0) + (CELL_W+1)'(m.col);
		m.map = map | (MAP_W'(1) << pos[CELL_W-1:0]);
		return m;
	endfunction

endpackage

@@ hw/rtl/sopkm_parse.sv @@
// Expression parser: variable table, term bits, fault tracking and cell marking.
module sopkm_parse import sopkm_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              fire,
	input  logic [CHAR_W-1:0] char_code,
	input  logic              last_char,
	input  logic [CHAR_W-1:0] sum_symbol,
	input  logic [CHAR_W-1:0] negation_symbol,
	output push_t             push
);

	logic [CHAR_W-1:0]   names_q [MAX_VARS];
	logic [CNT_W-1:0]    cnt_q;
	logic [MAX_VARS-1:0] bits_q;
	logic                first_q;
	logic                pend_q;
	logic [MAP_W-1:0]    map_q;
	logic [FLT_W-1:0]    fault_q;

	logic [CNT_W-1:0]    cnt_d;
	logic [MAX_VARS-1:0] bits_d;
	logic                first_d;
	logic                pend_d;
	logic [MAP_W-1:0]    map_d;
	logic [FLT_W-1:0]    fault_d;
	logic                name_we;

	logic [MAX_VARS-1:0] match;
	logic [MAX_VARS-1:0] sel;
	logic                is_sum;
	logic                is_neg;
	mark_t               mark_a;
	mark_t               mark_b;
	result_t             res_a;
	result_t             res_b;

	always_comb begin
		for (int i = 0; i < MAX_VARS; i++) begin
			match[i] = (CNT_W'(i) < cnt_q) && (names_q[i] == char_code);
		end
	end

	assign is_sum = (char_code == sum_symbol);
	assign is_neg = !is_sum && (char_code == negation_symbol);

	always_comb begin
		cnt_d   = cnt_q;
		bits_d  = bits_q;
		first_d = first_q;
		pend_d  = pend_q;
		map_d   = map_q;
		fault_d = fault_q;
		name_we = 1'b0;
		sel     = '0;
		mark_a  = '0;
		mark_b  = '0;
		res_a   = '0;
		res_b   = '0;

		if (is_sum) begin
			if (pend_d)
				fault_d = set_fault(fault_d, FLT_NEGATION);
			pend_d = 1'b0;
			mark_a = mark_cell(bits_d, cnt_d, map_d);
			map_d  = mark_a.map;
			res_a  = '{cell_row: mark_a.row, cell_column: mark_a.col, map_cells: map_d,
				var_total: cnt_d, term_status: fault_d, expression_end: 1'b0};
			fault_d = FLT_NONE;
			first_d = 1'b0;
		end else if (is_neg) begin
			if (pend_d)
				fault_d = set_fault(fault_d, FLT_NEGATION);
			pend_d = 1'b1;
		end else begin
			if (first_d) begin
				if (|match) begin
					fault_d = set_fault(fault_d, FLT_REPEAT);
				end else if (cnt_d >= CNT_W'(MAX_VARS)) begin
					fault_d = set_fault(fault_d, FLT_TOO_MANY);
				end else begin
					sel     = MAX_VARS'(1) << cnt_d;
					name_we = 1'b1;
					cnt_d   = cnt_d + CNT_W'(1);
				end
			end else begin
				sel = match;
				if (!(|match))
					fault_d = set_fault(fault_d, FLT_UNKNOWN);
			end
			bits_d = pend_d ? (bits_d & ~sel) : (bits_d | sel);
			pend_d = 1'b0;
		end

		if (last_char) begin
			if (pend_d)
				fault_d = set_fault(fault_d, FLT_NEGATION);
			mark_b = mark_cell(bits_d, cnt_d, map_d);
			res_b  = '{cell_row: mark_b.row, cell_column: mark_b.col, map_cells: mark_b.map,
				var_total: cnt_d, term_status: fault_d, expression_end: 1'b1};
			cnt_d   = '0;
			bits_d  = '0;
			first_d = 1'b1;
			pend_d  = 1'b0;
			map_d   = '0;
			fault_d = FLT_NONE;
		end
	end

	// A sum character as the final character yields two results.
	always_comb begin
		push.count  = 2'(is_sum) + 2'(last_char);
		push.first  = is_sum ? res_a : res_b;
		push.second = res_b;
		if (!fire)
			push.count = 2'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= '0;
			bits_q  <= '0;
			first_q <= 1'b1;
			pend_q  <= 1'b0;
			map_q   <= '0;
			fault_q <= FLT_NONE;
		end else if (fire) begin
			cnt_q   <= cnt_d;
			bits_q  <= bits_d;
			first_q <= first_d;
			pend_q  <= pend_d;
			map_q   <= map_d;
			fault_q <= fault_d;
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < MAX_VARS; i++) begin
			if (fire && name_we && cnt_q == CNT_W'(i))
				names_q[i] <= char_code;
		end
	end

endmodule

@@ hw/rtl/sopkm_out_fifo.sv @@
// Four-entry result queue that takes up to two results per cycle.
module sopkm_out_fifo import sopkm_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  push_t   push,
	output logic    room_two,
	output logic    out_valid,
	input  logic    out_ready,
	output result_t head
);

	localparam int DEPTH = 4;
	localparam int PTR_W = 2;

	result_t          entry_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [PTR_W:0]   count_q;
	logic             pop;

	assign out_valid = (count_q != '0);
	assign pop       = out_valid && out_ready;
	assign room_two  = (count_q <= (PTR_W+1)'(DEPTH - 2));
	assign head      = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push.count != 2'd0)
			entry_q[wr_ptr_q] <= push.first;
		if (push.count == 2'd2)
			entry_q[wr_ptr_q + PTR_W'(1)] <= push.second;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + PTR_W'(push.count);
			if (pop)
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			count_q <= count_q + (PTR_W+1)'(push.count) - (PTR_W+1)'(pop);
		end
	end

endmodule

@@ hw/rtl/sop_text_to_kmap_marker.sv @@
// Top level of the sum-of-products text to Karnaugh map marker.
// The input channel (in_valid/in_ready) carries one character of the expression per
// transfer, with last_char set on the final character. The output channel
// (out_valid/out_ready) carries one marked cell per transfer, together with the whole
// map, the variable count, the fault of the term just ended and an end flag.
// A transfer lands in an input register; the character is then parsed once the queue
// has room, and its results are written to a four-entry output queue that drives
// out_valid. The block takes one character per cycle while the queue has room for two
// results. A sum character or a final character adds one result, a final sum character
// adds two, and the output side drains one result per cycle, so sustained rate is
// bounded by the result count when out_ready stays high.
// The parser advances only when the queue has room for two results; when the
// receiver stalls the queue fills, the input register holds and in_ready drops.
// Configuration writes (cfg_wr_en, cfg_index, cfg_data) take effect at the next edge
// and are expected only while the block is idle.
// Reset sets the sum symbol to '+' and the negation symbol to an apostrophe, clears
// the variable count, term bits, map and faults, and empties the queue.
module sop_text_to_kmap_marker import sopkm_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_wr_en,
	input  logic              cfg_index,
	input  logic [CHAR_W-1:0] cfg_data,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [CHAR_W-1:0] char_code,
	input  logic              last_char,
	output logic              out_valid,
	input  logic              out_ready,
	output logic              cell_row,
	output logic [COL_W-1:0]  cell_column,
	output logic [MAP_W-1:0]  map_cells,
	output logic [CNT_W-1:0]  var_total,
	output logic [FLT_W-1:0]  term_status,
	output logic              expression_end
);

	logic [CHAR_W-1:0] sum_q;
	logic [CHAR_W-1:0] neg_q;
	logic              valid_s1;
	logic [CHAR_W-1:0] char_s1;
	logic              last_s1;
	logic              fire;
	logic              room_two;
	push_t             push;
	result_t           head;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= SUM_RESET;
			neg_q <= NEG_RESET;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_SUM: sum_q <= cfg_data;
				REG_NEG: neg_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign fire     = valid_s1 && room_two;
	assign in_ready = !valid_s1 || fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			char_s1 <= char_code;
			last_s1 <= last_char;
		end
	end

	sopkm_parse u_parse (
		.clk             (clk),
		.arst_n          (arst_n),
		.fire            (fire),
		.char_code       (char_s1),
		.last_char       (last_s1),
		.sum_symbol      (sum_q),
		.negation_symbol (neg_q),
		.push            (push)
	);

	sopkm_out_fifo u_out_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.room_two  (room_two),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.head      (head)
	);

	assign cell_row       = head.cell_row;
	assign cell_column    = head.cell_column;
	assign map_cells      = head.map_cells;
	assign var_total      = head.var_total;
	assign term_status    = head.term_status;
	assign expression_end = head.expression_end;

endmodule
